// ===== rtl/viewport_tile_window_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Viewport tile window unit assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef VIEWPORT_TILE_WINDOW_UNIT_DEFINES_SVH
`define VIEWPORT_TILE_WINDOW_UNIT_DEFINES_SVH

// same-cycle implication
`define VPTW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VPTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vptw_pkg.sv =====
// ---------------------------------------------------------------------------
// Viewport tile window package
// Shared constants and types of the viewport tile window unit.
// ---------------------------------------------------------------------------
package vptw_pkg;

  localparam int TILE_CAP_MAX_DEF = 64;
  localparam int COORD_BITS_DEF   = 32;

  localparam int CAP_W   = 7;
  localparam int SIZE_W  = 24;
  localparam int ORIG_W  = 32;
  localparam int OUT_W   = 32;
  localparam int IDX_W   = 8;
  localparam int DATA_W  = 32;

  localparam logic [IDX_W-1:0] REG_ORIGIN_EAST  = 8'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_NORTH = 8'd1;
  localparam logic [IDX_W-1:0] REG_CELL_SIZE    = 8'd2;
  localparam logic [IDX_W-1:0] REG_TILE_CAP     = 8'd3;

  localparam logic [SIZE_W-1:0] CELL_SIZE_RST = 24'd1600;
  localparam logic [CAP_W-1:0]  TILE_CAP_RST  = 7'd64;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_rsp_t;

endpackage

// ===== rtl/vptw_if.sv =====
// ---------------------------------------------------------------------------
// Viewport tile window channel interfaces
// View input, tile output and configuration write channels.
// ---------------------------------------------------------------------------
interface vptw_in_if #(
  parameter int COORD_BITS = vptw_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] view_min_east;
  logic signed [COORD_BITS-1:0] view_min_north;
  logic signed [COORD_BITS-1:0] view_max_east;
  logic signed [COORD_BITS-1:0] view_max_north;

  modport source (output valid, view_min_east, view_min_north, view_max_east,
                  view_max_north, input ready);
  modport sink   (input valid, view_min_east, view_min_north, view_max_east,
                  view_max_north, output ready);
endinterface

interface vptw_out_if ();
  logic                                valid;
  logic                                ready;
  logic signed [vptw_pkg::OUT_W-1:0]   cell_column;
  logic signed [vptw_pkg::OUT_W-1:0]   cell_row;
  logic                                last_tile;

  modport source (output valid, cell_column, cell_row, last_tile, input ready);
  modport sink   (input valid, cell_column, cell_row, last_tile, output ready);
endinterface

interface vptw_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [vptw_pkg::IDX_W-1:0]      index;
  logic [vptw_pkg::DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/vptw_div.sv =====
// ---------------------------------------------------------------------------
// Viewport tile window divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module vptw_div #(
  parameter int NB = 33
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [NB-1:0]               dividend,
  input  logic [vptw_pkg::SIZE_W-1:0] divisor,
  output logic [NB-1:0]               quot,
  output logic                        busy,
  output vptw_pkg::div_rsp_t          rsp
);
  localparam int SW = vptw_pkg::SIZE_W;
  localparam int CW = $clog2(NB + 1);

  logic [SW-1:0] rem_r, rem_nxt;
  logic [NB-1:0] q_r, q_nxt;
  logic [SW-1:0] d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW:0]   sh;
  logic          ge;

  always_comb begin
    sh       = {rem_r, q_r[NB-1]};
    ge       = (sh >= {1'b0, d_r});
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      cnt_nxt  = CW'(NB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? SW'(sh - {1'b0, d_r}) : sh[SW-1:0];
      q_nxt   = {q_r[NB-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) d_r <= divisor;
  end

  assign quot       = q_r;
  assign busy       = busy_r;
  assign rsp.done   = done_r;
  assign rsp.rem_nz = (rem_r != '0);

endmodule

// ===== rtl/viewport_tile_window_unit.sv =====
// ---------------------------------------------------------------------------
// Viewport tile window unit
// Maps a view rectangle to grid cells and emits a capped, centered window.
// ---------------------------------------------------------------------------
// One view at a time. The four corner-to-cell divisions run on one shared
// restoring divider at one bit per cycle. The column search tries one
// candidate per cycle and, like the further divider pass that gives the
// rows, runs only when the view needs a window. Then one tile leaves per
// cycle while the sink is ready. in_ch.ready is low while a view is in work.
`include "viewport_tile_window_unit_defines.svh"

module viewport_tile_window_unit #(
  parameter int TILE_CAP_MAX = vptw_pkg::TILE_CAP_MAX_DEF,
  parameter int COORD_BITS   = vptw_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vptw_cfg_if.sink    cfg_ch,
  vptw_in_if.sink     in_ch,
  vptw_out_if.source  out_ch
);
  localparam int CAPW = vptw_pkg::CAP_W;
  localparam int XW   = (COORD_BITS > 32) ? COORD_BITS : 32;
  localparam int NB   = XW + 1;
  localparam int CW   = COORD_BITS + 2;
  localparam int KKW  = 2 * CAPW - 1;
  localparam logic signed [NB:0] QMAX = (NB+1)'((64'sd1 <<< (COORD_BITS-1)) - 64'sd1);
  localparam logic signed [NB:0] QMIN = -QMAX - (NB+1)'(1);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DSTART = 9'b000000010,
    ST_DWAIT  = 9'b000000100,
    ST_SIZE   = 9'b000001000,
    ST_SEARCH = 9'b000010000,
    ST_RSTART = 9'b000100000,
    ST_RWAIT  = 9'b001000000,
    ST_PLACE  = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [vptw_pkg::ORIG_W-1:0] oe_r, on_r;
  logic [vptw_pkg::SIZE_W-1:0]        size_r;
  logic [CAPW-1:0]                    tcap_r;

  logic signed [COORD_BITS-1:0] crd_r [4];
  logic signed [COORD_BITS-1:0] crd_nxt [4];
  logic signed [COORD_BITS-1:0] idx_r [4];
  logic [1:0]                   sel_r, sel_nxt;
  logic [CAPW-1:0]              cap_r, cap_nxt, cap_eff;
  logic [NB-1:0]                w_r, w_nxt, h_r, h_nxt;
  logic [NB-1:0]                w_c, h_c;
  logic [NB+CAPW-1:0]           capw_r, capw_nxt;
  logic [CAPW-1:0]              k_r, k_nxt, cols_r, cols_nxt, rows_r, rows_nxt;
  logic [KKW-1:0]               kk_r, kk_nxt;
  logic [CAPW-1:0]              ci_r, ci_nxt, ri_r, ri_nxt;
  logic signed [CW-1:0]         fc_r, fc_nxt, c_r, c_nxt, r_r, r_nxt;

  logic                         ov_r, ov_nxt, olast_r, olast_nxt;
  logic signed [vptw_pkg::OUT_W-1:0] ocol_r, ocol_nxt, orow_r, orow_nxt;

  // divider hookup
  logic                         div_start, div_busy;
  logic [NB-1:0]                div_dvd, div_q;
  logic [vptw_pkg::SIZE_W-1:0]  div_dsr;
  vptw_pkg::div_rsp_t           div_rsp;

  logic signed [NB-1:0]         num;
  logic                         num_neg;
  logic signed [NB:0]           q_full, q_sat;
  logic [13:0]                  small_area;
  logic                         need_win;
  logic [NB+KKW-1:0]            prod;
  logic [CAPW-1:0]              cand;
  logic signed [CW-1:0]         lo_c, hi_c, f_c;
  logic signed [CW+vptw_pkg::OUT_W-1:0] c_ext, r_ext;
  logic                         in_fire, out_fire, last_now, load;

  vptw_div #(.NB(NB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quot     (div_q),
    .busy     (div_busy),
    .rsp      (div_rsp)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = ov_r && out_ch.ready;
  assign cap_eff      = (tcap_r > CAPW'(TILE_CAP_MAX)) ? CAPW'(TILE_CAP_MAX) : tcap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oe_r   <= '0;
      on_r   <= '0;
      size_r <= vptw_pkg::CELL_SIZE_RST;
      tcap_r <= vptw_pkg::TILE_CAP_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        vptw_pkg::REG_ORIGIN_EAST:  oe_r   <= cfg_ch.data;
        vptw_pkg::REG_ORIGIN_NORTH: on_r   <= cfg_ch.data;
        vptw_pkg::REG_CELL_SIZE:    size_r <= cfg_ch.data[vptw_pkg::SIZE_W-1:0];
        vptw_pkg::REG_TILE_CAP:     tcap_r <= cfg_ch.data[CAPW-1:0];
        default: ;
      endcase
    end
  end

  // coordinate minus origin, magnitude to the divider
  always_comb begin
    num     = NB'(crd_r[sel_r]) - NB'(sel_r[1] ? on_r : oe_r);
    num_neg = num[NB-1];
    div_dvd = num_neg ? NB'(-num) : NB'(num);
    div_dsr = (size_r == '0) ? vptw_pkg::SIZE_W'(1) : size_r;
    if (state_r == ST_RSTART) begin
      div_dvd = NB'(cap_r);
      div_dsr = vptw_pkg::SIZE_W'(cols_r);
    end
    div_start = (state_r == ST_DSTART) || (state_r == ST_RSTART);
  end

  // floor and saturate
  always_comb begin
    q_full = num_neg ? (-$signed({1'b0, div_q}) - (NB+1)'(div_rsp.rem_nz))
                     : $signed({1'b0, div_q});
    if (q_full < QMIN)      q_sat = QMIN;
    else if (q_full > QMAX) q_sat = QMAX;
    else                    q_sat = q_full;
  end

  always_comb begin
    w_c        = NB'(idx_r[1]) - NB'(idx_r[0]) + NB'(1);
    h_c        = NB'(idx_r[3]) - NB'(idx_r[2]) + NB'(1);
    small_area = 14'(w_c[CAPW-1:0]) * 14'(h_c[CAPW-1:0]);
    need_win   = (h_c > NB'(cap_r)) || (w_c > NB'(cap_r)) || (small_area > 14'(cap_r));
    prod       = (NB+KKW)'(kk_r) * (NB+KKW)'(h_r);
  end

  // window placement, shared by columns and rows
  function automatic logic signed [CW-1:0] place(input logic signed [CW-1:0] lo,
                                                 input logic signed [CW-1:0] hi,
                                                 input logic [CAPW-1:0] n);
    logic signed [CW-1:0] mid, t, up;
    mid = lo + ((hi - lo) >>> 1);
    t   = mid - CW'(n >> 1);
    up  = hi - CW'(n) + CW'(1);
    if (t < lo)      return lo;
    else if (t > up) return up;
    else             return t;
  endfunction

  always_comb begin
    lo_c  = CW'(idx_r[0]);
    hi_c  = CW'(idx_r[1]);
    f_c   = place(lo_c, hi_c, cols_r);
  end

  always_comb begin
    state_nxt = state_r;
    crd_nxt   = crd_r;
    sel_nxt   = sel_r;
    cap_nxt   = cap_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    capw_nxt  = capw_r;
    k_nxt     = k_r;
    kk_nxt    = kk_r;
    cols_nxt  = cols_r;
    rows_nxt  = rows_r;
    ci_nxt    = ci_r;
    ri_nxt    = ri_r;
    fc_nxt    = fc_r;
    c_nxt     = c_r;
    r_nxt     = r_r;
    ov_nxt    = out_fire ? 1'b0 : ov_r;
    ocol_nxt  = ocol_r;
    orow_nxt  = orow_r;
    olast_nxt = olast_r;
    cand      = cols_r;
    last_now  = (ci_r == cols_r - 1'b1) && (ri_r == rows_r - 1'b1);
    load      = (state_r == ST_EMIT) && (!ov_r || out_ch.ready);
    c_ext     = (CW+vptw_pkg::OUT_W)'(c_r);
    r_ext     = (CW+vptw_pkg::OUT_W)'(r_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && cap_eff != '0) begin
          crd_nxt[0] = (in_ch.view_min_east < in_ch.view_max_east) ?
                       in_ch.view_min_east : in_ch.view_max_east;
          crd_nxt[1] = (in_ch.view_min_east < in_ch.view_max_east) ?
                       in_ch.view_max_east : in_ch.view_min_east;
          crd_nxt[2] = (in_ch.view_min_north < in_ch.view_max_north) ?
                       in_ch.view_min_north : in_ch.view_max_north;
          crd_nxt[3] = (in_ch.view_min_north < in_ch.view_max_north) ?
                       in_ch.view_max_north : in_ch.view_min_north;
          cap_nxt    = cap_eff;
          sel_nxt    = 2'd0;
          state_nxt  = ST_DSTART;
        end
      end
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_rsp.done) begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = (sel_r == 2'd3) ? ST_SIZE : ST_DSTART;
        end
      end
      ST_SIZE: begin
        w_nxt = w_c;
        h_nxt = h_c;
        if (need_win) begin
          capw_nxt  = (NB+CAPW)'(cap_r) * (NB+CAPW)'(w_c);
          k_nxt     = CAPW'(1);
          kk_nxt    = KKW'(1);
          cols_nxt  = CAPW'(1);
          state_nxt = ST_SEARCH;
        end else begin
          cols_nxt  = w_c[CAPW-1:0];
          rows_nxt  = h_c[CAPW-1:0];
          state_nxt = ST_PLACE;
        end
      end
      ST_SEARCH: begin
        // k*k*h grows with k: the last candidate that fits wins
        if (prod <= (NB+KKW)'(capw_r)) begin
          cand = k_r;
          if (k_r == cap_r) begin
            cols_nxt  = (w_r < NB'(cand)) ? w_r[CAPW-1:0] : cand;
            state_nxt = ST_RSTART;
          end else begin
            cols_nxt = cand;
            k_nxt    = k_r + 1'b1;
            kk_nxt   = kk_r + KKW'({k_r, 1'b1});
          end
        end else begin
          cols_nxt  = (w_r < NB'(cand)) ? w_r[CAPW-1:0] : cand;
          state_nxt = ST_RSTART;
        end
      end
      ST_RSTART: state_nxt = ST_RWAIT;
      ST_RWAIT: begin
        if (div_rsp.done) begin
          rows_nxt  = (NB'(div_q[CAPW-1:0]) > h_r) ? h_r[CAPW-1:0] : div_q[CAPW-1:0];
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        fc_nxt    = f_c;
        c_nxt     = f_c;
        r_nxt     = place(CW'(idx_r[2]), CW'(idx_r[3]), rows_r);
        ci_nxt    = '0;
        ri_nxt    = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          ov_nxt    = 1'b1;
          ocol_nxt  = c_ext[vptw_pkg::OUT_W-1:0];
          orow_nxt  = r_ext[vptw_pkg::OUT_W-1:0];
          olast_nxt = last_now;
          if (ci_r == cols_r - 1'b1) begin
            ci_nxt = '0;
            c_nxt  = fc_r;
            ri_nxt = ri_r + 1'b1;
            r_nxt  = r_r + CW'(1);
          end else begin
            ci_nxt = ci_r + 1'b1;
            c_nxt  = c_r + CW'(1);
          end
          if (last_now) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    crd_r   <= crd_nxt;
    sel_r   <= sel_nxt;
    cap_r   <= cap_nxt;
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    capw_r  <= capw_nxt;
    k_r     <= k_nxt;
    kk_r    <= kk_nxt;
    cols_r  <= cols_nxt;
    rows_r  <= rows_nxt;
    ci_r    <= ci_nxt;
    ri_r    <= ri_nxt;
    fc_r    <= fc_nxt;
    c_r     <= c_nxt;
    r_r     <= r_nxt;
    ocol_r  <= ocol_nxt;
    orow_r  <= orow_nxt;
    olast_r <= olast_nxt;
    if (state_r == ST_DWAIT && div_rsp.done) idx_r[sel_r] <= COORD_BITS'(q_sat);
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.cell_column = ocol_r;
  assign out_ch.cell_row    = orow_r;
  assign out_ch.last_tile   = olast_r;

  `VPTW_ASSERT_NEXT(a_busy_after_accept, in_fire && cap_eff != '0, !in_ch.ready,
                    "ready high right after a view")
  `VPTW_ASSERT_IMPL(a_emit_dims, state_r == ST_EMIT, cols_r != '0 && rows_r != '0,
                    "empty window while emitting")
  `VPTW_ASSERT_IMPL(a_div_owner, div_busy, state_r == ST_DWAIT || state_r == ST_RWAIT,
                    "divider running outside a wait state")

endmodule
